// File: rtl/bsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and codes for the bytecode structure checker.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int TOTAL_W = 33;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_LIMIT   = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_MALF    = 3'd4;
  localparam logic [2:0] ST_BADVER  = 3'd5;
  localparam logic [2:0] ST_BADTVER = 3'd6;

  localparam logic [1:0] CFG_MAX_BYTES   = 2'd0;
  localparam logic [1:0] CFG_MAX_STRINGS = 2'd1;
  localparam logic [1:0] CFG_MAX_PROTOS  = 2'd2;

  localparam logic [31:0] VARINT_MAX = 32'h0fff_ffff;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               byte_present;
    logic               last;
    logic [TOTAL_W-1:0] byte_total;
  } bsc_item_t;

endpackage
`default_nettype wire

// File: rtl/bytecode_structure_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bytecode_structure_checker
// Streaming structure check of a compiled script image, at most one byte per beat.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle, set by the parser step, while the result side does not stall.
// Result path: the last input beat is written into a queue entry when accepted;
//   the parser reads it from there and, once the result side is free, the status
//   beat is held in the parser result register.
// Reset: rst_n low clears the queue, parse state and result valid, and
//   loads the limit registers with their defaults.
module bytecode_structure_checker
  import bsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [27:0]      out_main_index,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic      push, q_full, q_valid, q_pop;
  bsc_item_t f_item, q_item;

  assign in_stall = q_full;

  bsc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_byte_present,
    .in_last, .push, .item(f_item)
  );

  bsc_queue u_queue (
    .clk, .rst_n, .push, .item_in(f_item), .full(q_full), .pop(q_pop),
    .not_empty(q_valid), .item_out(q_item)
  );

  bsc_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .out_valid, .out_stall, .out_status, .out_main_index
  );

endmodule
`default_nettype wire

// File: rtl/bsc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_front
// Accepts input beats, keeps the saturating byte count of the image and
// tags each beat with it.
// ----------------------------------------------------------------------------
module bsc_front
  import bsc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic      in_byte_present,
  input  wire logic      in_last,
  output logic           push,
  output bsc_item_t      item
);

  logic [TOTAL_W-1:0] total_r, total_nxt, total_inc;

  assign push = in_valid && !in_stall;

  always_comb begin
    total_inc = total_r;
    if (in_byte_present && (total_r != {TOTAL_W{1'b1}})) begin
      total_inc = total_r + TOTAL_W'(1);
    end
    total_nxt = total_r;
    if (push) begin
      total_nxt = in_last ? '0 : total_inc;
    end
  end

  always_comb begin
    item.data_byte    = in_data_byte;
    item.byte_present = in_byte_present;
    item.last         = in_last;
    item.byte_total   = total_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/bsc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_queue
// Two-entry queue between the front and the parser.
// ----------------------------------------------------------------------------
module bsc_queue
  import bsc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire bsc_item_t item_in,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output bsc_item_t      item_out
);

  bsc_item_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign item_out  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/bsc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_back
// Parser: walks the image structure one byte per beat, holds the limit
// registers and drives the registered status result.
// ----------------------------------------------------------------------------
module bsc_back
  import bsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire bsc_item_t   q_item,
  output logic             q_pop,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [27:0]      out_main_index
);

  localparam logic [5:0] PH_VER = 6'd0, PH_TVER = 6'd1, PH_SCOUNT = 6'd2,
    PH_STR_LOOP = 6'd3, PH_SLEN = 6'd4, PH_SSKIP = 6'd5, PH_TYPES_CHECK = 6'd6,
    PH_TIDX = 6'd7, PH_TVAR = 6'd8, PH_PCOUNT = 6'd9, PH_PROTO_LOOP = 6'd10,
    PH_HDR = 6'd11, PH_TLEN = 6'd12, PH_TSKIP = 6'd13, PH_SIZECODE = 6'd14,
    PH_CSKIP = 6'd15, PH_SIZEK = 6'd16, PH_K_LOOP = 6'd17, PH_KTAG = 6'd18,
    PH_KSKIP = 6'd19, PH_KVAR = 6'd20, PH_KKEYS = 6'd21, PH_KEY_LOOP = 6'd22,
    PH_KEY = 6'd23, PH_SIZEP = 6'd24, PH_P_LOOP = 6'd25, PH_CHILD = 6'd26,
    PH_LINEDEF = 6'd27, PH_DNAME = 6'd28, PH_LFLAG = 6'd29, PH_LGAP = 6'd30,
    PH_LSKIP = 6'd31, PH_DFLAG = 6'd32, PH_NLOC = 6'd33, PH_LV_LOOP = 6'd34,
    PH_LV_NAME = 6'd35, PH_LV_START = 6'd36, PH_LV_END = 6'd37, PH_LV_REG = 6'd38,
    PH_NUPV = 6'd39, PH_UV_LOOP = 6'd40, PH_UV = 6'd41, PH_MAIN = 6'd42,
    PH_DONE = 6'd43;

  logic [31:0] max_bytes_r;
  logic [16:0] max_strings_r;
  logic [13:0] max_protos_r;

  logic [5:0]  ph_r, ph;
  logic [7:0]  fv_r, fv;
  logic [1:0]  tv_r, tv;
  logic [31:0] vv_r, vv;
  logic [2:0]  vp_r, vp;
  logic [34:0] skip_r, skip;
  logic [31:0] outer_r, outer;
  logic [31:0] inner_r, inner;
  logic [31:0] key_r, key;
  logic [31:0] cwc_r, cwc;
  logic [2:0]  fe_r, fe;
  logic        es_r, es;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [27:0] idx_r, idx_nxt;

  logic [7:0]  b;
  logic        go, vph, fail, inproto, hold, out_free;
  logic [2:0]  fail_code;
  logic [31:0] part, sh, intervals;

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_main_index = idx_r;
  assign out_free       = !out_valid_r || !out_stall;
  assign q_pop          = q_valid && out_free;

  function automatic logic is_varint(input logic [5:0] p);
    unique case (p)
      PH_SCOUNT, PH_SLEN, PH_TVAR, PH_PCOUNT, PH_TLEN, PH_SIZECODE, PH_SIZEK,
      PH_KVAR, PH_KKEYS, PH_KEY, PH_SIZEP, PH_CHILD, PH_LINEDEF, PH_DNAME,
      PH_NLOC, PH_LV_NAME, PH_LV_START, PH_LV_END, PH_NUPV, PH_UV,
      PH_MAIN: is_varint = 1'b1;
      default: is_varint = 1'b0;
    endcase
  endfunction

  always_comb begin
    ph = ph_r; fv = fv_r; tv = tv_r; vv = vv_r; vp = vp_r; skip = skip_r;
    outer = outer_r; inner = inner_r; key = key_r; cwc = cwc_r;
    fe = fe_r; es = es_r;
    b = q_item.data_byte;
    go = 1'b0; vph = 1'b0; fail = 1'b0; fail_code = ST_MALF;
    part = '0; sh = '0; intervals = '0; hold = 1'b0;
    inproto = 1'b0;
    status_nxt = status_r; idx_nxt = idx_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (q_item.byte_present && !es_r) begin
      go  = 1'b1;
      vph = is_varint(ph_r);
      inproto = (ph_r >= PH_HDR) && (ph_r <= PH_UV);
      if (vph) begin
        part = 32'({1'b0, b[6:0]}) << (6'(vp_r) * 6'd7);
        vv   = ((vp_r == 3'd0) ? 32'd0 : vv_r) | part;
        if (!b[7]) begin
          vp = 3'd0;
          if (vv > VARINT_MAX) begin
            fail = 1'b1; fail_code = inproto ? ST_MALF : ST_TRUNC;
          end
        end else if (vp_r >= 3'd4) begin
          fail = 1'b1; fail_code = inproto ? ST_MALF : ST_TRUNC;
        end else begin
          vp = vp_r + 3'd1;
          go = 1'b0;
        end
        if (fail) go = 1'b0;
      end
      if (go) begin
        unique case (ph_r)
          PH_VER: begin
            fv = b;
            if (b == 8'd0) begin
              fail = 1'b1; fail_code = ST_MALF;
            end else if (b < 8'd3 || b > 8'd6) begin
              fail = 1'b1; fail_code = ST_BADVER;
            end else begin
              ph = (b >= 8'd4) ? PH_TVER : PH_SCOUNT;
            end
          end
          PH_TVER: begin
            if (b < 8'd1 || b > 8'd3) begin
              fail = 1'b1; fail_code = ST_BADTVER;
            end else begin
              tv = b[1:0]; ph = PH_SCOUNT;
            end
          end
          PH_SCOUNT: begin
            if (vv > 32'(max_strings_r)) begin
              fail = 1'b1; fail_code = ST_LIMIT;
            end else begin
              outer = vv; ph = PH_STR_LOOP;
            end
          end
          PH_SLEN: begin skip = 35'(vv); ph = PH_SSKIP; end
          PH_SSKIP, PH_HDR, PH_TSKIP, PH_CSKIP, PH_KSKIP, PH_LSKIP: begin
            if (skip != '0) skip = skip - 35'd1;
          end
          PH_TIDX: ph = (b != 8'd0) ? PH_TVAR : PH_PCOUNT;
          PH_TVAR: ph = PH_TIDX;
          PH_PCOUNT: begin
            if (vv > 32'(max_protos_r)) begin
              fail = 1'b1; fail_code = ST_LIMIT;
            end else begin
              outer = vv; ph = PH_PROTO_LOOP;
            end
          end
          PH_TLEN: begin skip = 35'(vv); ph = PH_TSKIP; end
          PH_SIZECODE: begin
            cwc = vv; skip = {1'b0, vv, 2'b00}; ph = PH_CSKIP;
          end
          PH_SIZEK: begin inner = vv; ph = PH_K_LOOP; end
          PH_KTAG: begin
            unique case (b)
              8'd0: ph = PH_K_LOOP;
              8'd1: begin skip = 35'd1;  ph = PH_KSKIP; end
              8'd2: begin skip = 35'd8;  ph = PH_KSKIP; end
              8'd4: begin skip = 35'd4;  ph = PH_KSKIP; end
              8'd7: begin skip = 35'd16; ph = PH_KSKIP; end
              8'd3, 8'd6: ph = PH_KVAR;
              8'd5: ph = PH_KKEYS;
              default: begin fail = 1'b1; fail_code = ST_MALF; end
            endcase
          end
          PH_KVAR: ph = PH_K_LOOP;
          PH_KKEYS: begin key = vv; ph = PH_KEY_LOOP; end
          PH_KEY: ph = PH_KEY_LOOP;
          PH_SIZEP: begin inner = vv; ph = PH_P_LOOP; end
          PH_CHILD: ph = PH_P_LOOP;
          PH_LINEDEF: ph = PH_DNAME;
          PH_DNAME: ph = PH_LFLAG;
          PH_LFLAG: ph = (b != 8'd0) ? PH_LGAP : PH_DFLAG;
          PH_LGAP: begin
            sh = (b >= 8'd32) ? 32'd0 : ((cwc_r - 32'd1) >> b[4:0]);
            intervals = sh + 32'd1;
            skip = 35'(cwc_r) + 35'({intervals, 2'b00});
            ph = PH_LSKIP;
          end
          PH_DFLAG: ph = (b != 8'd0) ? PH_NLOC : PH_PROTO_LOOP;
          PH_NLOC: begin inner = vv; ph = PH_LV_LOOP; end
          PH_LV_NAME: ph = PH_LV_START;
          PH_LV_START: ph = PH_LV_END;
          PH_LV_END: ph = PH_LV_REG;
          PH_LV_REG: ph = PH_LV_LOOP;
          PH_NUPV: begin inner = vv; ph = PH_UV_LOOP; end
          PH_UV: ph = PH_UV_LOOP;
          PH_MAIN: ph = PH_DONE;
          default: begin fail = 1'b1; fail_code = ST_MALF; end
        endcase
      end
      if (fail) begin
        es = 1'b1; fe = fail_code; go = 1'b0;
      end
      // resolve phases that consume no byte; chains are at most four long
      if (go) begin
        for (int i = 0; i < 4; i++) begin
          if (!hold) begin
            priority case (ph)
              PH_STR_LOOP: begin
                if (outer == '0) ph = PH_TYPES_CHECK;
                else begin outer = outer - 32'd1; ph = PH_SLEN; end
              end
              PH_SSKIP: begin
                if (skip != '0) hold = 1'b1; else ph = PH_STR_LOOP;
              end
              PH_TYPES_CHECK: ph = (tv == 2'd3) ? PH_TIDX : PH_PCOUNT;
              PH_PROTO_LOOP: begin
                hold = 1'b1;
                if (outer == '0) ph = PH_MAIN;
                else begin
                  outer = outer - 32'd1;
                  skip  = (fv >= 8'd4) ? 35'd5 : 35'd4;
                  ph    = PH_HDR;
                end
              end
              PH_HDR: begin
                if (skip != '0) hold = 1'b1;
                else ph = (fv >= 8'd4) ? PH_TLEN : PH_SIZECODE;
              end
              PH_TSKIP: begin
                if (skip != '0) hold = 1'b1; else ph = PH_SIZECODE;
              end
              PH_CSKIP: begin
                if (skip != '0) hold = 1'b1; else ph = PH_SIZEK;
              end
              PH_K_LOOP: begin
                if (inner == '0) ph = PH_SIZEP;
                else begin inner = inner - 32'd1; ph = PH_KTAG; end
              end
              PH_KSKIP: begin
                if (skip != '0) hold = 1'b1; else ph = PH_K_LOOP;
              end
              PH_KEY_LOOP: begin
                if (key == '0) ph = PH_K_LOOP;
                else begin key = key - 32'd1; ph = PH_KEY; end
              end
              PH_P_LOOP: begin
                if (inner == '0) ph = PH_LINEDEF;
                else begin inner = inner - 32'd1; ph = PH_CHILD; end
              end
              PH_LSKIP: begin
                if (skip != '0) hold = 1'b1; else ph = PH_DFLAG;
              end
              PH_LV_LOOP: begin
                if (inner == '0) ph = PH_NUPV;
                else begin inner = inner - 32'd1; ph = PH_LV_NAME; end
              end
              PH_UV_LOOP: begin
                if (inner == '0) ph = PH_PROTO_LOOP;
                else begin inner = inner - 32'd1; ph = PH_UV; end
              end
              default: hold = 1'b1;
            endcase
          end
        end
      end
    end

    if (q_pop && q_item.last) begin
      out_valid_nxt = 1'b1;
      idx_nxt = '0;
      if (q_item.byte_total == '0) status_nxt = ST_EMPTY;
      else if (q_item.byte_total > {1'b0, max_bytes_r}) status_nxt = ST_LIMIT;
      else if (es) status_nxt = fe;
      else if (ph != PH_DONE) begin
        status_nxt = ((ph >= PH_HDR) && (ph <= PH_UV)) ? ST_MALF : ST_TRUNC;
      end else begin
        status_nxt = ST_OK; idx_nxt = vv[27:0];
      end
      // clear parse state for the next image
      ph = PH_VER; fv = '0; tv = '0; vv = '0; vp = '0; skip = '0;
      outer = '0; inner = '0; key = '0; cwc = '0; fe = '0; es = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r   <= 32'd16777216;
      max_strings_r <= 17'd65536;
      max_protos_r  <= 14'd8192;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_BYTES:   max_bytes_r   <= cfg_data;
        CFG_MAX_STRINGS: max_strings_r <= cfg_data[16:0];
        CFG_MAX_PROTOS:  max_protos_r  <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_VER; fv_r <= '0; tv_r <= '0; vv_r <= '0; vp_r <= '0;
      skip_r <= '0; outer_r <= '0; inner_r <= '0; key_r <= '0; cwc_r <= '0;
      fe_r <= '0; es_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        ph_r <= ph; fv_r <= fv; tv_r <= tv; vv_r <= vv; vp_r <= vp;
        skip_r <= skip; outer_r <= outer; inner_r <= inner; key_r <= key;
        cwc_r <= cwc; fe_r <= fe; es_r <= es;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_bytecode_structure_checker.sv
// ----------------------------------------------------------------------------
// tb_bytecode_structure_checker
// Streams script images into the checker one beat at a time. Images are
// generated well formed with random content, then some are cut short,
// corrupted or padded, and some are noise. A predictor of the parser
// supplies the expected status beat for each image, compared field by field.
// ----------------------------------------------------------------------------
module tb_bytecode_structure_checker;
  import bsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [5:0] {
    P_VER, P_TVER, P_SCOUNT, P_STR_LOOP, P_SLEN, P_SSKIP, P_TYPES_CHECK, P_TIDX,
    P_TVAR, P_PCOUNT, P_PROTO_LOOP, P_HDR, P_TLEN, P_TSKIP, P_SIZECODE, P_CSKIP,
    P_SIZEK, P_K_LOOP, P_KTAG, P_KSKIP, P_KVAR, P_KKEYS, P_KEY_LOOP, P_KEY,
    P_SIZEP, P_P_LOOP, P_CHILD, P_LINEDEF, P_DNAME, P_LFLAG, P_LGAP, P_LSKIP,
    P_DFLAG, P_NLOC, P_LV_LOOP, P_LV_NAME, P_LV_START, P_LV_END, P_LV_REG,
    P_NUPV, P_UV_LOOP, P_UV, P_MAIN, P_DONE
  } phase_t;

  localparam logic [32:0] TOTAL_SAT = 33'h1_ffff_ffff;
  localparam int          TIMEOUT   = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [27:0] out_main_index;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  bytecode_structure_checker uut (.*);

  // limit registers and parser state as the predictor sees them
  logic [31:0] lim_bytes;
  logic [16:0] lim_strings;
  logic [13:0] lim_protos;
  phase_t      phase;
  logic [7:0]  fmt_ver;
  logic [1:0]  type_ver;
  logic [31:0] vacc;
  logic [2:0]  vpos;
  logic [34:0] skip_left;
  logic [31:0] outer_left, inner_left, key_left, code_words;
  logic [32:0] bytes_seen;
  logic [2:0]  first_err;
  logic        err_seen;

  logic [2:0]  status_q[$];
  logic [27:0] index_q[$];
  logic [7:0]  img[$];

  int mismatches = 0;
  int items_sent = 0;
  int cycles = 0;
  int hold_left = 0;
  bit quiet = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  function automatic void clear_parse();
    phase = P_VER; fmt_ver = 0; type_ver = 0; vacc = 0; vpos = 0;
    skip_left = 0; outer_left = 0; inner_left = 0; key_left = 0;
    code_words = 0; bytes_seen = 0; first_err = 0; err_seen = 0;
  endfunction

  function automatic bit in_proto();
    return phase >= P_HDR && phase <= P_UV;
  endfunction

  function automatic void flag_error(logic [2:0] code);
    if (!err_seen) begin
      err_seen = 1;
      first_err = code;
    end
  endfunction

  function automatic bit varint_phase(phase_t p);
    case (p)
      P_SCOUNT, P_SLEN, P_TVAR, P_PCOUNT, P_TLEN, P_SIZECODE, P_SIZEK, P_KVAR,
      P_KKEYS, P_KEY, P_SIZEP, P_CHILD, P_LINEDEF, P_DNAME, P_NLOC, P_LV_NAME,
      P_LV_START, P_LV_END, P_NUPV, P_UV, P_MAIN: return 1;
      default: return 0;
    endcase
  endfunction

  // walk through phases that consume no byte
  function automatic void settle();
    forever begin
      case (phase)
        P_STR_LOOP: begin
          if (outer_left == 0) phase = P_TYPES_CHECK;
          else begin outer_left--; phase = P_SLEN; end
        end
        P_SSKIP: begin
          if (skip_left != 0) return;
          phase = P_STR_LOOP;
        end
        P_TYPES_CHECK: phase = (type_ver == 3) ? P_TIDX : P_PCOUNT;
        P_PROTO_LOOP: begin
          if (outer_left == 0) begin phase = P_MAIN; return; end
          outer_left--;
          skip_left = (fmt_ver >= 4) ? 35'd5 : 35'd4;
          phase = P_HDR;
          return;
        end
        P_HDR: begin
          if (skip_left != 0) return;
          phase = (fmt_ver >= 4) ? P_TLEN : P_SIZECODE;
        end
        P_TSKIP: begin
          if (skip_left != 0) return;
          phase = P_SIZECODE;
        end
        P_CSKIP: begin
          if (skip_left != 0) return;
          phase = P_SIZEK;
        end
        P_K_LOOP: begin
          if (inner_left == 0) phase = P_SIZEP;
          else begin inner_left--; phase = P_KTAG; end
        end
        P_KSKIP: begin
          if (skip_left != 0) return;
          phase = P_K_LOOP;
        end
        P_KEY_LOOP: begin
          if (key_left == 0) phase = P_K_LOOP;
          else begin key_left--; phase = P_KEY; end
        end
        P_P_LOOP: begin
          if (inner_left == 0) phase = P_LINEDEF;
          else begin inner_left--; phase = P_CHILD; end
        end
        P_LSKIP: begin
          if (skip_left != 0) return;
          phase = P_DFLAG;
        end
        P_LV_LOOP: begin
          if (inner_left == 0) phase = P_NUPV;
          else begin inner_left--; phase = P_LV_NAME; end
        end
        P_UV_LOOP: begin
          if (inner_left == 0) phase = P_PROTO_LOOP;
          else begin inner_left--; phase = P_UV; end
        end
        default: return;
      endcase
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic [31:0] v;
    logic [31:0] part;
    logic [31:0] sh;
    logic [63:0] wide;
    v = 0;
    if (varint_phase(phase)) begin
      part = {25'd0, b[6:0]} << (7 * vpos);
      vacc = (vpos == 0 ? 32'd0 : vacc) | part;
      if (!b[7]) begin
        vpos = 0;
        if (vacc > VARINT_MAX) begin
          flag_error(in_proto() ? ST_MALF : ST_TRUNC);
          return;
        end
      end else begin
        if (vpos >= 4) begin
          flag_error(in_proto() ? ST_MALF : ST_TRUNC);
          return;
        end
        vpos++;
        return;
      end
      v = vacc;
    end
    case (phase)
      P_VER: begin
        fmt_ver = b;
        if (b == 0) begin flag_error(ST_MALF); return; end
        if (b < 3 || b > 6) begin flag_error(ST_BADVER); return; end
        phase = (b >= 4) ? P_TVER : P_SCOUNT;
      end
      P_TVER: begin
        if (b < 1 || b > 3) begin flag_error(ST_BADTVER); return; end
        type_ver = b[1:0];
        phase = P_SCOUNT;
      end
      P_SCOUNT: begin
        if (v > lim_strings) begin flag_error(ST_LIMIT); return; end
        outer_left = v; phase = P_STR_LOOP;
      end
      P_SLEN: begin skip_left = 35'(v); phase = P_SSKIP; end
      P_SSKIP, P_HDR, P_TSKIP, P_CSKIP, P_KSKIP, P_LSKIP:
        if (skip_left != 0) skip_left--;
      P_TIDX: phase = (b != 0) ? P_TVAR : P_PCOUNT;
      P_TVAR: phase = P_TIDX;
      P_PCOUNT: begin
        if (v > lim_protos) begin flag_error(ST_LIMIT); return; end
        outer_left = v; phase = P_PROTO_LOOP;
      end
      P_TLEN: begin skip_left = 35'(v); phase = P_TSKIP; end
      P_SIZECODE: begin
        code_words = v;
        skip_left = {3'd0, v} << 2;
        phase = P_CSKIP;
      end
      P_SIZEK: begin inner_left = v; phase = P_K_LOOP; end
      P_KTAG: begin
        case (b)
          0: phase = P_K_LOOP;
          1: begin skip_left = 35'd1; phase = P_KSKIP; end
          2: begin skip_left = 35'd8; phase = P_KSKIP; end
          4: begin skip_left = 35'd4; phase = P_KSKIP; end
          7: begin skip_left = 35'd16; phase = P_KSKIP; end
          3, 6: phase = P_KVAR;
          5: phase = P_KKEYS;
          default: begin flag_error(ST_MALF); return; end
        endcase
      end
      P_KVAR: phase = P_K_LOOP;
      P_KKEYS: begin key_left = v; phase = P_KEY_LOOP; end
      P_KEY: phase = P_KEY_LOOP;
      P_SIZEP: begin inner_left = v; phase = P_P_LOOP; end
      P_CHILD: phase = P_P_LOOP;
      P_LINEDEF: phase = P_DNAME;
      P_DNAME: phase = P_LFLAG;
      P_LFLAG: phase = (b != 0) ? P_LGAP : P_DFLAG;
      P_LGAP: begin
        // shifts of 32 or more give zero; the interval count wraps at 32 bits
        sh = (b >= 32) ? 32'd0 : ((code_words - 32'd1) >> b);
        wide = {32'd0, code_words} + {30'd0, sh + 32'd1, 2'b00};
        skip_left = wide[34:0];
        phase = P_LSKIP;
      end
      P_DFLAG: phase = (b != 0) ? P_NLOC : P_PROTO_LOOP;
      P_NLOC: begin inner_left = v; phase = P_LV_LOOP; end
      P_LV_NAME: phase = P_LV_START;
      P_LV_START: phase = P_LV_END;
      P_LV_END: phase = P_LV_REG;
      P_LV_REG: phase = P_LV_LOOP;
      P_NUPV: begin inner_left = v; phase = P_UV_LOOP; end
      P_UV: phase = P_UV_LOOP;
      P_MAIN: phase = P_DONE;
      default: begin flag_error(ST_MALF); return; end
    endcase
    settle();
  endfunction

  function automatic void predict_beat(logic [7:0] b, logic present, logic last);
    logic [2:0] st;
    logic [27:0] idx;
    if (present) begin
      if (bytes_seen < TOTAL_SAT) bytes_seen++;
      if (!err_seen) parse_byte(b);
    end
    if (!last) return;
    idx = 0;
    if (bytes_seen == 0) st = ST_EMPTY;
    else if (bytes_seen > {1'b0, lim_bytes}) st = ST_LIMIT;
    else if (err_seen) st = first_err;
    else if (phase != P_DONE) st = in_proto() ? ST_MALF : ST_TRUNC;
    else begin st = ST_OK; idx = vacc[27:0]; end
    status_q.push_back(st);
    index_q.push_back(idx);
    clear_parse();
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 0;
    else if (hold_left > 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
    end else out_stall <= !quiet && ($urandom_range(99) < 13);
  end

  // sample mid-cycle; the beat is taken at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected status beat: status=%0d index=%0d", out_status,
                   out_main_index);
      end else begin
        if (out_status !== status_q[0] || out_main_index !== index_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("status mismatch: exp %0d/%0d got %0d/%0d", status_q[0],
                     index_q[0], out_status, out_main_index);
        end
        void'(status_q.pop_front());
        void'(index_q.pop_front());
      end
    end
  end

  // ---------------- drivers ----------------
  task automatic send_beat(logic [7:0] b, logic present, logic last);
    if (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data_byte <= b;
    in_byte_present <= present;
    in_last <= last;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    predict_beat(b, present, last);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      CFG_MAX_BYTES: lim_bytes = val;
      CFG_MAX_STRINGS: lim_strings = val[16:0];
      CFG_MAX_PROTOS: lim_protos = val[13:0];
      default: ;
    endcase
  endtask

  // push img as one image; optionally close with a marker beat carrying no byte
  task automatic send_image(bit marker);
    int n;
    n = img.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 5) send_beat(8'($urandom), 0, 0);
      send_beat(img[i], 1, !marker && i == n - 1);
    end
    if (marker || n == 0) send_beat(8'($urandom), 0, 1);
  endtask

  // ---------------- image builder ----------------
  function automatic void put_varint(logic [31:0] v, bit pad);
    while (v >= 128) begin
      img.push_back({1'b1, v[6:0]});
      v = v >> 7;
    end
    if (pad) begin
      img.push_back({1'b1, v[6:0]});
      img.push_back(8'h00);
    end else img.push_back({1'b0, v[6:0]});
  endfunction

  function automatic void put_bytes(int n);
    repeat (n) img.push_back(8'($urandom));
  endfunction

  function automatic void put_rv(int hi);
    put_varint($urandom_range(hi), $urandom_range(9) == 0);
  endfunction

  function automatic void build_image(int ver, int tver, int nstr, int nproto,
                                      logic [31:0] main_idx);
    int cw, nk, tag, gap, sh;
    img.delete();
    img.push_back(8'(ver));
    if (ver >= 4) img.push_back(8'(tver));
    put_varint(nstr, 0);
    repeat (nstr) begin
      cw = $urandom_range(5);
      put_varint(cw, 0);
      put_bytes(cw);
    end
    if (tver == 3) begin
      repeat ($urandom_range(2)) begin
        img.push_back(8'($urandom_range(255, 1)));
        put_rv(300);
      end
      img.push_back(8'd0);
    end
    put_varint(nproto, 0);
    repeat (nproto) begin
      put_bytes(ver >= 4 ? 5 : 4);
      if (ver >= 4) begin
        cw = $urandom_range(3);
        put_varint(cw, 0);
        put_bytes(cw);
      end
      cw = $urandom_range(3);
      put_varint(cw, $urandom_range(5) == 0);
      put_bytes(cw * 4);
      nk = $urandom_range(2);
      put_varint(nk, 0);
      repeat (nk) begin
        tag = $urandom_range(7);
        img.push_back(8'(tag));
        case (tag)
          1: put_bytes(1);
          2: put_bytes(8);
          4: put_bytes(4);
          7: put_bytes(16);
          3, 6: put_rv(20000);
          5: begin
            gap = $urandom_range(2);
            put_varint(gap, 0);
            repeat (gap) put_rv(500);
          end
          default: ;
        endcase
      end
      nk = $urandom_range(2);
      put_varint(nk, 0);
      repeat (nk) put_rv(200);
      put_rv(70000);
      put_rv(300);
      if ($urandom_range(1)) begin
        img.push_back(8'($urandom_range(255, 1)));
        gap = (cw == 0 || $urandom_range(4) == 0) ? $urandom_range(255, 32)
                                                  : $urandom_range(31);
        sh = (gap >= 32) ? 0 : ((cw - 1) >> gap);
        img.push_back(8'(gap));
        put_bytes(cw + (sh + 1) * 4);
      end else img.push_back(8'd0);
      if ($urandom_range(1)) begin
        img.push_back(8'($urandom_range(255, 1)));
        nk = $urandom_range(2);
        put_varint(nk, 0);
        repeat (nk) begin
          put_rv(100); put_rv(100); put_rv(100);
          put_bytes(1);
        end
        nk = $urandom_range(2);
        put_varint(nk, 0);
        repeat (nk) put_rv(100);
      end else img.push_back(8'd0);
    end
    put_varint(main_idx, 0);
  endfunction

  function automatic void build_random();
    int ver;
    ver = $urandom_range(6, 3);
    build_image(ver, $urandom_range(3, 1), $urandom_range(3), $urandom_range(3, 1),
                $urandom_range(3) == 0 ? $urandom : $urandom_range(40));
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    int bad_ver[4] = '{0, 2, 7, 255};
    // empty image: end marker only
    img.delete(); send_image(1);
    // bad version bytes
    foreach (bad_ver[i]) begin
      img.delete(); img.push_back(8'(bad_ver[i])); img.push_back(1);
      send_image(0);
    end
    // bad type version
    img.delete(); img.push_back(4); img.push_back(0); send_image(0);
    img.delete(); img.push_back(5); img.push_back(4); send_image(0);
    // minimal clean images for versions 3, 4 and 6
    build_image(3, 0, 0, 1, 0); send_image(0);
    build_image(4, 3, 2, 2, 32'h0fff_ffff); send_image(0);
    build_image(6, 1, 1, 1, 7); send_image(1);
    // oversized string count: truncated outside a prototype
    img.delete(); img.push_back(3);
    img.push_back(8'hff); img.push_back(8'hff); img.push_back(8'hff);
    img.push_back(8'hff); img.push_back(8'h0f); send_image(0);
    // varint running to a fifth continued byte
    img.delete(); img.push_back(3);
    repeat (5) img.push_back(8'h80);
    send_image(0);
    // unknown constant tag inside a prototype
    img.delete(); img.push_back(3); img.push_back(0); img.push_back(1);
    repeat (4) img.push_back(8'hc3);
    img.push_back(0); img.push_back(1); img.push_back(8);
    send_image(0);
    // oversized varint inside a prototype: malformed
    img.delete(); img.push_back(3); img.push_back(0); img.push_back(1);
    repeat (4) img.push_back(8'h3c);
    repeat (4) img.push_back(8'hff);
    img.push_back(8'h7f); send_image(0);
    // trailing byte after main index
    build_image(3, 0, 1, 1, 5); img.push_back(8'haa); send_image(0);
    // truncated in a proto and before protos
    build_image(4, 2, 1, 2, 3); img = img[0:img.size() - 4]; send_image(0);
    img.delete(); img.push_back(4); img.push_back(1); send_image(0);
  endtask

  task automatic test_limits();
    write_reg(CFG_MAX_STRINGS, 0);
    write_reg(CFG_MAX_PROTOS, 0);
    build_image(3, 0, 1, 1, 1); send_image(0);
    build_image(3, 0, 0, 1, 1); send_image(0);
    build_image(3, 0, 0, 0, 9); send_image(0);
    write_reg(CFG_MAX_STRINGS, 2);
    write_reg(CFG_MAX_PROTOS, 1);
    build_image(5, 3, 2, 1, 4); send_image(0);
    build_image(5, 3, 3, 1, 4); send_image(0);
    build_image(5, 3, 2, 2, 4); send_image(0);
    write_reg(CFG_MAX_BYTES, 0);
    build_image(3, 0, 0, 1, 2); send_image(0);
    img.delete(); send_image(1);
    write_reg(CFG_MAX_BYTES, 20);
    repeat (2) begin build_random(); send_image($urandom_range(1)); end
    write_reg(CFG_MAX_BYTES, 32'hffff_ffff);
    write_reg(CFG_MAX_STRINGS, 65536);
    write_reg(CFG_MAX_PROTOS, 8192);
  endtask

  task automatic test_backpressure();
    hold_left = 300;
    repeat (2) begin build_random(); send_image(0); end
  endtask

  task automatic test_random(int goal);
    int cut;
    while (items_sent < goal) begin
      case ($urandom_range(9))
        0: begin  // noise
          img.delete();
          put_bytes($urandom_range(12));
        end
        1: begin  // cut short
          build_random();
          cut = $urandom_range(img.size() - 1);
          while (img.size() > cut) void'(img.pop_back());
        end
        2: begin  // corrupt one byte
          build_random();
          img[$urandom_range(img.size() - 1)] = 8'($urandom);
        end
        3: begin  // trailing bytes
          build_random();
          put_bytes($urandom_range(3, 1));
        end
        default: build_random();
      endcase
      send_image($urandom_range(5) == 0);
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_data_byte = 0; in_byte_present = 0; in_last = 0;
    cfg_valid = 0; cfg_index = CFG_MAX_BYTES; cfg_data = 0;
    lim_bytes = 32'd16777216; lim_strings = 17'd65536; lim_protos = 14'd8192;
    clear_parse();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_limits();
    test_backpressure();
    quiet = 1;
    test_random(items_sent + 60);
    quiet = 0;
    write_reg(CFG_MAX_BYTES, 60);
    write_reg(CFG_MAX_STRINGS, 1);
    write_reg(CFG_MAX_PROTOS, 2);
    test_random(items_sent + 40);
    write_reg(CFG_MAX_BYTES, 32'd16777216);
    write_reg(CFG_MAX_STRINGS, 65536);
    write_reg(CFG_MAX_PROTOS, 8192);
    test_random(items_sent + 60);
    drain();
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
